@@ design/gdct_pkg.sv @@
// Shared types and constants of the gas scan duty-cycle tracker.
package gdct_pkg;

  localparam int SENSOR_COUNT    = 8;
  localparam int FIELDS_PER_POLL = 3;
  localparam int SENSOR_AW       = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_PARALLEL = 2'd1,
    MODE_SLEEP    = 2'd2
  } mode_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_WB
  } state_e;

  typedef enum logic [1:0] {
    WAKE_KEEP,
    WAKE_WAIT,
    WAKE_SLEEP
  } wake_sel_e;

  typedef struct packed {
    logic        func;
    logic [2:0]  sensor_index;
    logic [31:0] now_ms;
    logic [1:0]  field_count;
    logic [2:0]  valid_mask;
    logic [3:0]  gas_index_0;
    logic [3:0]  gas_index_1;
    logic [3:0]  gas_index_2;
    logic [3:0]  profile_length;
    logic [7:0]  repetitions;
    logic [31:0] sleep_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] accepted_mask;
    logic       miss_warning;
    mode_cmd_e  mode_command;
    logic       scanning;
  } out_item_t;

  // One sensor's schedule and profile, kept in the schedule RAM.
  typedef struct packed {
    logic        scanning;
    logic [31:0] wake_time;
    logic [4:0]  next_step;
    logic [7:0]  scan_count;
    logic [3:0]  step_count;
    logic [7:0]  scan_limit;
    logic [31:0] sleep_time;
  } entry_t;

endpackage

@@ design/gdct_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module gdct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/gas_scan_duty_cycle_tracker.sv @@
// Top level: per-sensor duty-cycle schedule kept in a RAM, updated per item.
// An item goes through read, compute and write back before its result is valid.
// A new item is taken only once the last one has left write back, because of the read-modify-write of the schedule
// RAM; a stalled result holds the write-back stage until the output register frees.
// Reset clears the configured bits, the wait register and all control state.
// RAM entries are not cleared; an entry is only used once a load has written it.
module gas_scan_duty_cycle_tracker
  import gdct_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  state_e   state_q, state_d;
  logic [15:0] gas_wait_q;
  logic [SENSOR_COUNT-1:0] configured_q;
  in_item_t item_q;

  entry_t    rd_entry, wr_entry;
  entry_t    upd_d, upd_q;
  out_item_t res_d, res_q, out_q;
  wake_sel_e wsel_d, wsel_q;
  logic      we_d, we_q;
  logic      cfg_set_d;
  logic      out_valid_q;
  logic      in_acc, wb_go, ram_we;
  logic [31:0] wake_add;

  assign in_acc = in_valid_i && !in_stall_o;
  assign wb_go  = (state_q == ST_WB) && !(out_valid_q && out_stall_i);
  assign ram_we = wb_go && we_q;

  gdct_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SENSOR_COUNT)
  ) u_sched_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (SENSOR_AW'(item_q.sensor_index)),
    .wdata_i (wr_entry),
    .re_i    (in_acc),
    .raddr_i (SENSOR_AW'(in_item_i.sensor_index)),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC: state_d = ST_WB;
      ST_WB: begin
        if (wb_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Field checks run as a short chain over the fetched fields of one poll.
  always_comb begin
    logic        in_range;
    logic        due;
    logic [4:0]  ns;
    logic [7:0]  sc;
    logic        stop;
    logic        slept;
    logic        miss;
    logic [2:0]  acc;
    logic [7:0]  gap;
    logic [4:0]  nxt;
    logic [3:0]  gidx [3];

    in_range = (int'(item_q.sensor_index) < SENSOR_COUNT);
    due      = item_q.now_ms >= rd_entry.wake_time;
    gidx[0]  = item_q.gas_index_0;
    gidx[1]  = item_q.gas_index_1;
    gidx[2]  = item_q.gas_index_2;
    ns       = rd_entry.next_step;
    sc       = rd_entry.scan_count;
    stop     = 1'b0;
    slept    = 1'b0;
    miss     = 1'b0;
    acc      = '0;
    gap      = '0;
    nxt      = '0;

    upd_d     = rd_entry;
    res_d     = '0;
    wsel_d    = WAKE_KEEP;
    we_d      = 1'b0;
    cfg_set_d = 1'b0;

    if (in_range) begin
      if (item_q.func) begin
        upd_d.scanning   = 1'b0;
        upd_d.wake_time  = '0;
        upd_d.next_step  = '0;
        upd_d.scan_count = '0;
        upd_d.step_count = item_q.profile_length;
        upd_d.scan_limit = item_q.repetitions;
        upd_d.sleep_time = item_q.sleep_ms;
        we_d      = 1'b1;
        cfg_set_d = 1'b1;
      end else begin
        if (configured_q[SENSOR_AW'(item_q.sensor_index)] && due) begin
          we_d = 1'b1;
          if (!rd_entry.scanning) begin
            upd_d.scanning     = 1'b1;
            upd_d.next_step    = '0;
            wsel_d             = WAKE_WAIT;
            res_d.mode_command = MODE_PARALLEL;
          end else begin
            for (int i = 0; i < FIELDS_PER_POLL; i++) begin
              if (!stop && (i < int'(item_q.field_count)) && item_q.valid_mask[i]) begin
                gap = {4'b0, gidx[i]} - {3'b0, ns};
                if (gap <= {4'b0, rd_entry.step_count}) begin
                  if (gap != 8'd0) miss = 1'b1;
                  acc[i] = 1'b1;
                  nxt    = {1'b0, gidx[i]} + 5'd1;
                  if (nxt == {1'b0, rd_entry.step_count}) begin
                    ns = '0;
                    sc = sc + 8'd1;
                    if (sc >= rd_entry.scan_limit) begin
                      sc    = '0;
                      slept = 1'b1;
                      stop  = 1'b1;
                    end
                  end else begin
                    ns = nxt;
                  end
                end
              end
            end
            upd_d.next_step     = ns;
            upd_d.scan_count    = sc;
            upd_d.scanning      = !slept;
            wsel_d              = slept ? WAKE_SLEEP : WAKE_WAIT;
            res_d.accepted_mask = acc;
            res_d.miss_warning  = miss;
            res_d.mode_command  = slept ? MODE_SLEEP : MODE_NONE;
          end
        end
        // an unconfigured sensor is sleeping, whatever its RAM entry holds
        res_d.scanning = configured_q[SENSOR_AW'(item_q.sensor_index)] && upd_d.scanning;
      end
    end
  end

  always_comb begin
    wake_add = '0;
    wr_entry = upd_q;
    unique case (wsel_q)
      WAKE_KEEP: wake_add = upd_q.wake_time;
      WAKE_WAIT: wake_add = item_q.now_ms + {16'b0, gas_wait_q};
      WAKE_SLEEP: wake_add = item_q.now_ms + upd_q.sleep_time;
      default: wake_add = upd_q.wake_time;
    endcase
    wr_entry.wake_time = wake_add;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gas_wait_q   <= '0;
      configured_q <= '0;
      we_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) gas_wait_q <= cfg_wdata_i;
      if (state_q == ST_CALC) begin
        we_q <= we_d;
        if (cfg_set_d) configured_q[SENSOR_AW'(item_q.sensor_index)] <= 1'b1;
      end
      if (wb_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_item_i;
    if (state_q == ST_CALC) begin
      upd_q  <= upd_d;
      res_q  <= res_d;
      wsel_q <= wsel_d;
    end
    if (wb_go) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_CALC)
    else $error("accepted item did not enter compute stage");

  a_calc_to_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CALC |=> state_q == ST_WB)
    else $error("compute stage not followed by write back");

  a_parallel_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.mode_command == MODE_PARALLEL |-> out_item_o.scanning)
    else $error("wake-up result does not report scanning");

  a_sleep_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.mode_command == MODE_SLEEP
      |-> !out_item_o.scanning && out_item_o.accepted_mask != 3'd0)
    else $error("sleep result inconsistent");

  a_miss_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.miss_warning |-> out_item_o.accepted_mask != 3'd0)
    else $error("miss warning without accepted field");
`endif

endmodule

@@ verif/gas_scan_duty_cycle_tracker_test.sv @@
// Self-checking testbench for the gas scan duty-cycle tracker.
module gas_scan_duty_cycle_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gdct_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 250;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  gas_scan_duty_cycle_tracker uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .out_valid_o,
    .out_stall_i,
    .out_item_o
  );

  always #10 clk_i = ~clk_i;

  // Predicted schedule, one entry per sensor; zero matches the reset state.
  bit [15:0] gas_wait_q;
  bit        cfgd          [SENSOR_COUNT];
  bit        scan_mode     [SENSOR_COUNT];
  bit [31:0] wake_at       [SENSOR_COUNT];
  bit [4:0]  step_next     [SENSOR_COUNT];
  bit [7:0]  scans_done    [SENSOR_COUNT];
  bit [3:0]  steps_per_scan[SENSOR_COUNT];
  bit [7:0]  scans_allowed [SENSOR_COUNT];
  bit [31:0] sleep_for     [SENSOR_COUNT];

  out_item_t expected_results[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        src_idle_pct = 14;
  int        sink_stall_pct = 14;
  int        hold_requests = 0;
  int        holds_done = 0;
  int        hold_left = 0;

  function automatic out_item_t schedule_step(input in_item_t it);
    out_item_t  r;
    logic [2:0] s;
    logic [3:0] g [3];
    logic [7:0] gap;
    int         n;
    r = '0;
    r.mode_command = MODE_NONE;
    s = it.sensor_index;
    g[0] = it.gas_index_0;
    g[1] = it.gas_index_1;
    g[2] = it.gas_index_2;
    if (it.func) begin
      steps_per_scan[s] = it.profile_length;
      scans_allowed[s]  = it.repetitions;
      sleep_for[s]      = it.sleep_ms;
      cfgd[s]           = 1'b1;
      scan_mode[s]      = 1'b0;
      wake_at[s]        = '0;
      step_next[s]      = '0;
      scans_done[s]     = '0;
    end else begin
      if (cfgd[s] && it.now_ms >= wake_at[s]) begin
        if (!scan_mode[s]) begin
          scan_mode[s] = 1'b1;
          step_next[s] = '0;
          wake_at[s] = it.now_ms + 32'(gas_wait_q);
          r.mode_command = MODE_PARALLEL;
        end else begin
          n = (int'(it.field_count) > FIELDS_PER_POLL) ? FIELDS_PER_POLL
                                                        : int'(it.field_count);
          for (int k = 0; k < n; k++) begin
            if (!it.valid_mask[k]) continue;
            // gap wraps at 8 bits, so a step behind the expected one is a huge gap
            gap = 8'(g[k]) - 8'(step_next[s]);
            if (gap > 8'(steps_per_scan[s])) continue;
            if (gap != 8'd0) r.miss_warning = 1'b1;
            r.accepted_mask[k] = 1'b1;
            step_next[s] = 5'(g[k]) + 5'd1;
            if (step_next[s] == 5'(steps_per_scan[s])) begin
              step_next[s] = '0;
              scans_done[s] = scans_done[s] + 8'd1;
              if (scans_done[s] >= scans_allowed[s]) begin
                scans_done[s] = '0;
                scan_mode[s] = 1'b0;
                wake_at[s] = it.now_ms + sleep_for[s];
                r.mode_command = MODE_SLEEP;
                break;
              end
            end
            wake_at[s] = it.now_ms + 32'(gas_wait_q);
          end
          if (r.accepted_mask == 3'b000) wake_at[s] = it.now_ms + 32'(gas_wait_q);
        end
      end
      r.scanning = scan_mode[s];
    end
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.func           = 1'($urandom);
    it.sensor_index   = 3'($urandom);
    it.now_ms         = $urandom;
    it.field_count    = 2'($urandom);
    it.valid_mask     = 3'($urandom);
    it.gas_index_0    = 4'($urandom);
    it.gas_index_1    = 4'($urandom);
    it.gas_index_2    = 4'($urandom);
    it.profile_length = 4'($urandom);
    it.repetitions    = 8'($urandom);
    it.sleep_ms       = $urandom;
    return it;
  endfunction

  function automatic in_item_t load_item(input logic [2:0] s, input logic [3:0] len,
                                         input logic [7:0] reps, input logic [31:0] sleep);
    in_item_t it;
    it = random_item();
    it.func = 1'b1;
    it.sensor_index = s;
    it.profile_length = len;
    it.repetitions = reps;
    it.sleep_ms = sleep;
    return it;
  endfunction

  function automatic in_item_t poll_item(input logic [2:0] s, input logic [31:0] now,
                                         input logic [1:0] cnt, input logic [2:0] mask,
                                         input logic [3:0] g0, input logic [3:0] g1,
                                         input logic [3:0] g2);
    in_item_t it;
    it = random_item();
    it.func = 1'b0;
    it.sensor_index = s;
    it.now_ms = now;
    it.field_count = cnt;
    it.valid_mask = mask;
    it.gas_index_0 = g0;
    it.gas_index_1 = g1;
    it.gas_index_2 = g2;
    return it;
  endfunction

  // Mostly short profiles and few repetitions so that scans end and sensors sleep.
  function automatic in_item_t make_load(input logic [2:0] s);
    in_item_t it;
    it = load_item(s, 4'($urandom), 8'($urandom), $urandom);
    if ($urandom_range(99) < 85) begin
      it.profile_length = 4'($urandom_range(1, 4));
      it.repetitions = 8'($urandom_range(0, 3));
      it.sleep_ms = $urandom_range(0, 200);
    end
    return it;
  endfunction

  // Polls that are mostly due and carry the heater steps the sensor expects next.
  function automatic in_item_t make_poll(input logic [2:0] s);
    in_item_t   it;
    logic [3:0] g [3];
    logic [3:0] nxt;
    int         roll;
    it = random_item();
    it.func = 1'b0;
    it.sensor_index = s;
    roll = $urandom_range(99);
    if (roll < 85) it.now_ms = wake_at[s] + $urandom_range(0, 30);
    else if (roll < 93) it.now_ms = wake_at[s] - $urandom_range(1, 30);
    if ($urandom_range(99) < 80) begin
      it.field_count = 2'd3;
      it.valid_mask = 3'b111;
    end
    nxt = step_next[s][3:0];
    for (int k = 0; k < 3; k++) begin
      roll = $urandom_range(99);
      if (roll < 80) g[k] = nxt;
      else if (roll < 90) g[k] = nxt + 4'($urandom_range(1, 2));
      else g[k] = 4'($urandom);
      nxt = g[k] + 4'd1;
      if (nxt == steps_per_scan[s]) nxt = '0;
    end
    it.gas_index_0 = g[0];
    it.gas_index_1 = g[1];
    it.gas_index_2 = g[2];
    return it;
  endfunction

  function automatic in_item_t next_random_item();
    logic [2:0] s;
    s = 3'($urandom_range(0, SENSOR_COUNT - 1));
    if ($urandom_range(99) < 4) return make_load(s);
    return make_poll(s);
  endfunction

  task automatic send_item(input in_item_t it);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(schedule_step(it));
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_all_results();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_gas_wait(input logic [15:0] value);
    wait_all_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    gas_wait_q = value;
  endtask

  task automatic test_unconfigured_poll();
    send_item(poll_item(3'd3, 32'hFFFF_FFFF, 2'd3, 3'b111, 4'd0, 4'd1, 4'd2));
    send_item(poll_item(3'd7, 32'h0, 2'd0, 3'b000, 4'd15, 4'd15, 4'd15));
    stop_sending();
  endtask

  // Wake, one full scan into sleep, early and on-time polls, reload mid-scan.
  task automatic test_scan_cycle();
    send_item(load_item(3'd0, 4'd3, 8'd1, 32'd100));
    send_item(poll_item(3'd0, 32'd0, 2'd0, 3'b000, 4'd0, 4'd0, 4'd0));
    send_item(poll_item(3'd0, 32'd0, 2'd3, 3'b111, 4'd0, 4'd1, 4'd2));
    send_item(poll_item(3'd0, 32'd99, 2'd3, 3'b111, 4'd0, 4'd1, 4'd2));
    send_item(poll_item(3'd0, 32'd100, 2'd1, 3'b000, 4'd0, 4'd0, 4'd0));
    send_item(poll_item(3'd0, 32'd100, 2'd2, 3'b101, 4'd0, 4'd1, 4'd2));
    send_item(load_item(3'd0, 4'd3, 8'd1, 32'd100));
    send_item(poll_item(3'd0, 32'd5, 2'd3, 3'b111, 4'd0, 4'd1, 4'd2));
    stop_sending();
  endtask

  // Wake time wraps past 2^32; skipped, missed and empty fields.
  task automatic test_time_wrap();
    send_item(load_item(3'd1, 4'd15, 8'd255, 32'hFFFF_FFFF));
    send_item(poll_item(3'd1, 32'hFFFF_FFF0, 2'd0, 3'b000, 4'd0, 4'd0, 4'd0));
    send_item(poll_item(3'd1, 32'h0, 2'd3, 3'b111, 4'd0, 4'd0, 4'd0));
    send_item(poll_item(3'd1, 32'hFFFF_FFFF, 2'd3, 3'b111, 4'd5, 4'd0, 4'd6));
    send_item(poll_item(3'd1, 32'hFFFF_FFFF, 2'd0, 3'b111, 4'd7, 4'd7, 4'd7));
    stop_sending();
  endtask

  // Zero length, zero repetitions (sleep stops the field walk), step counter past 15.
  task automatic test_odd_profiles();
    send_item(load_item(3'd2, 4'd0, 8'd0, 32'd0));
    send_item(poll_item(3'd2, 32'd0, 2'd0, 3'b000, 4'd0, 4'd0, 4'd0));
    send_item(poll_item(3'd2, 32'd5, 2'd3, 3'b111, 4'd0, 4'd1, 4'd3));
    send_item(load_item(3'd4, 4'd1, 8'd0, 32'h8000_0000));
    send_item(poll_item(3'd4, 32'h7000_0000, 2'd3, 3'b111, 4'd0, 4'd0, 4'd0));
    send_item(poll_item(3'd4, 32'h7000_0005, 2'd3, 3'b111, 4'd0, 4'd0, 4'd0));
    send_item(poll_item(3'd4, 32'hF000_0004, 2'd3, 3'b111, 4'd0, 4'd0, 4'd0));
    send_item(load_item(3'd5, 4'd15, 8'd1, 32'd0));
    send_item(poll_item(3'd5, 32'd0, 2'd0, 3'b000, 4'd0, 4'd0, 4'd0));
    send_item(poll_item(3'd5, 32'd5, 2'd3, 3'b111, 4'd15, 4'd0, 4'd14));
    stop_sending();
  endtask

  task automatic test_random_schedule(input int count);
    for (int s = 0; s < SENSOR_COUNT; s++) send_item(make_load(3'(s)));
    repeat (count) send_item(next_random_item());
    stop_sending();
  endtask

  // Output held off for a long stretch while items keep coming, so the input stalls.
  task automatic test_back_pressure(input int count);
    src_idle_pct = 0;
    hold_requests++;
    repeat (count) send_item(next_random_item());
    stop_sending();
    src_idle_pct = 14;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unconfigured_poll();
    set_gas_wait(16'd0);
    test_scan_cycle();
    set_gas_wait(16'hFFFF);
    test_time_wrap();
    set_gas_wait(16'd5);
    test_odd_profiles();
    set_gas_wait(16'($urandom_range(1, 40)));
    test_random_schedule(400);
    // a long run with no gaps on either side
    src_idle_pct = 0;
    sink_stall_pct = 0;
    test_random_schedule(150);
    src_idle_pct = 14;
    sink_stall_pct = 14;
    set_gas_wait(16'hFFFF);
    test_random_schedule(200);
    test_back_pressure(80);
    set_gas_wait(16'd0);
    test_random_schedule(250);
    wait_all_results();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("gas_scan_duty_cycle_tracker verification clean");
    end else begin
      $display("gas_scan_duty_cycle_tracker verification failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_result
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none actual %h",
                 $realtime, out_item_o);
      end else begin
        want = expected_results.pop_front();
        check_field("accepted_mask", 8'(want.accepted_mask), 8'(out_item_o.accepted_mask));
        check_field("miss_warning", 8'(want.miss_warning), 8'(out_item_o.miss_warning));
        check_field("mode_command", 8'(want.mode_command), 8'(out_item_o.mode_command));
        check_field("scanning", 8'(want.scanning), 8'(out_item_o.scanning));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gas_scan_duty_cycle_tracker verification failed");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
design/gdct_pkg.sv
design/gdct_ram.sv
design/gas_scan_duty_cycle_tracker.sv
verif/gas_scan_duty_cycle_tracker_test.sv
